@@ rtl/core/ira_pkg.sv @@
`timescale 1ns / 1ps

package ira_pkg;

    // Default number of rooms that can be opened.
    localparam int MAX_ROOMS_DEF = 256;

    // Fixed field widths of the item and result channels.
    localparam int TIME_W  = 32;
    localparam int INDEX_W = 16;
    localparam int ROOM_W  = 9;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // latch the accepted item and restart the scan
        logic issue;   // read the next room end time
        logic commit;  // decide, update the room table and load the result
    } ira_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // no room is open yet
        logic scan_last;   // the current read address is the last open room
        logic out_free;    // the result register can take a new result now
    } ira_sts_t;

endpackage

@@ rtl/core/ira_ram.sv @@
`timescale 1ns / 1ps

module ira_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/ira_ctrl.sv @@
`timescale 1ns / 1ps

module ira_ctrl
    import ira_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  ira_sts_t sts,
    output ira_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.count_zero)
                    begin
                        state_next = ST_DECIDE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // The last read data is compared in this cycle.
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/ira_dp.sv @@
`timescale 1ns / 1ps

module ira_dp
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ira_cmd_t           cmd,
    output ira_sts_t           sts,
    input  logic [TIME_W-1:0]  start_time,
    input  logic [TIME_W-1:0]  end_time,
    input  logic [INDEX_W-1:0] item_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] out_index,
    output logic [ROOM_W-1:0]  room_number,
    output logic [ROOM_W-1:0]  rooms_in_use,
    output logic               overflow
);

    localparam int AW = $clog2(MAX_ROOMS);
    localparam int CW = $clog2(MAX_ROOMS + 1);

    // Control state.
    logic [CW-1:0]      count_reg;
    logic               out_valid_reg;
    logic               pending_reg;
    logic               first_reg;

    // Payload state.
    logic [TIME_W-1:0]  start_reg;
    logic [TIME_W-1:0]  end_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [AW-1:0]      scan_addr_reg;
    logic [AW-1:0]      cmp_addr_reg;
    logic [TIME_W-1:0]  best_end_reg;
    logic [AW-1:0]      best_room_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [ROOM_W-1:0]  room_number_reg;
    logic [ROOM_W-1:0]  rooms_in_use_reg;
    logic               overflow_reg;

    logic [TIME_W-1:0]  rdata;
    logic               take_new;
    logic               reuse;
    logic               full;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      room_w;
    logic               we;
    logic [AW-1:0]      waddr;

    ira_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_ROOMS)
    ) u_room_end (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (end_reg),
        .re    (cmd.issue),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    // The scan keeps the first strict minimum, so ties go to the lower room.
    assign take_new = pending_reg && (first_reg || (rdata < best_end_reg));

    assign reuse = (count_reg != '0) && (start_reg > best_end_reg);
    assign full  = (count_reg == CW'(MAX_ROOMS));

    always_comb
    begin
        count_next = count_reg;
        room_w     = '0;
        we         = 1'b0;
        waddr      = best_room_reg;
        if (reuse)
        begin
            room_w = CW'(best_room_reg) + CW'(1);
            we     = cmd.commit;
        end
        else if (!full)
        begin
            count_next = count_reg + CW'(1);
            room_w     = count_next;
            waddr      = count_reg[AW-1:0];
            we         = cmd.commit;
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = ((CW'(scan_addr_reg) + CW'(1)) == count_reg);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pending_reg   <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            pending_reg <= cmd.issue;
            if (cmd.load)
            begin
                first_reg <= 1'b1;
            end
            else if (pending_reg)
            begin
                first_reg <= 1'b0;
            end
            if (cmd.commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_reg     <= start_time;
            end_reg       <= end_time;
            index_reg     <= item_index;
            scan_addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
        end
        if (cmd.issue)
        begin
            cmp_addr_reg <= scan_addr_reg;
        end
        if (take_new)
        begin
            best_end_reg  <= rdata;
            best_room_reg <= cmp_addr_reg;
        end
        if (cmd.commit)
        begin
            out_index_reg    <= index_reg;
            room_number_reg  <= ROOM_W'(room_w);
            rooms_in_use_reg <= ROOM_W'(count_next);
            overflow_reg     <= !reuse && full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_index    = out_index_reg;
    assign room_number  = room_number_reg;
    assign rooms_in_use = rooms_in_use_reg;
    assign overflow     = overflow_reg;

endmodule

@@ rtl/core/interval_room_allocator.sv @@
// Sequence: an accepted item goes straight to the decide step when no room is open yet,
// and otherwise first through a scan of every open room and a drain step, plus any output stall.
// A new item is taken only after the last one is committed; the linear scan of the
// single-read-port room end table sets how soon that happens.
// Reset (rst_n, asynchronous, active low) clears the room count, the controller and
// the output valid; the room end table is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module interval_room_allocator
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    // Item channel: one booking interval per item, sorted by start then end.
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TIME_W-1:0]  start_time,
    input  logic [TIME_W-1:0]  end_time,
    input  logic [INDEX_W-1:0] item_index,

    // Result channel: one result item per accepted interval.
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] out_index,
    output logic [ROOM_W-1:0]  room_number,
    output logic [ROOM_W-1:0]  rooms_in_use,
    output logic               overflow
);

    // The controller sequences each item through a scan of the open rooms:
    // it issues one table read per cycle, the datapath keeps a running
    // minimum end time (ties go to the lower room number because only a
    // strictly smaller end time replaces the current best), and a final
    // decide step reuses that room, opens a new one or flags overflow. The
    // decide step waits until the result register is free, so a result
    // never overwrites one that has not been taken yet.
    ira_cmd_t cmd;
    ira_sts_t sts;

    ira_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ira_dp #(
        .MAX_ROOMS (MAX_ROOMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .start_time   (start_time),
        .end_time     (end_time),
        .item_index   (item_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_index    (out_index),
        .room_number  (room_number),
        .rooms_in_use (rooms_in_use),
        .overflow     (overflow)
    );

    // A result is only committed when the result register can take it.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
    else $error("result committed while the result register was occupied");

    // Table reads happen only while the item channel is held off and at
    // least one room is open.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (in_stall && !sts.count_zero))
    else $error("room table scanned outside an item or with no room open");

    // An overflow result never carries a room.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |-> (room_number == '0))
    else $error("overflow result carries a room number");

    // A commit always produces a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
    else $error("committed result not presented");

endmodule

@@ bench/interval_room_allocator_checker.sv @@
`timescale 1ns / 1ps

module interval_room_allocator_checker
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [TIME_W-1:0]  start_time,
    input  logic [TIME_W-1:0]  end_time,
    input  logic [INDEX_W-1:0] item_index,

    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [INDEX_W-1:0] out_index,
    input  logic [ROOM_W-1:0]  room_number,
    input  logic [ROOM_W-1:0]  rooms_in_use,
    input  logic               overflow,

    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [ROOM_W-1:0]  room;
        logic [ROOM_W-1:0]  in_use;
        logic               full;
    } booking_t;

    logic [TIME_W-1:0] room_free_at [MAX_ROOMS];
    int                rooms_opened = 0;
    booking_t          booked_q [$];
    int                error_count = 0;

    // Greedy placement: reuse the room that frees up first (lowest number on
    // a tie) if the interval starts strictly after it, otherwise open a room or flag overflow.
    function automatic booking_t assign_room(input logic [TIME_W-1:0]  s,
                                             input logic [TIME_W-1:0]  e,
                                             input logic [INDEX_W-1:0] idx);
        booking_t b;
        int       earliest;
        int       room;
        int       i;
        b        = '0;
        earliest = 0;
        room     = 0;
        if (rooms_opened > 0)
        begin
            for (i = 1; i < rooms_opened; i++)
                if (room_free_at[i] < room_free_at[earliest])
                    earliest = i;
            if (s > room_free_at[earliest])
            begin
                room_free_at[earliest] = e;
                room = earliest + 1;
            end
        end
        if (room == 0)
        begin
            if (rooms_opened < MAX_ROOMS)
            begin
                room_free_at[rooms_opened] = e;
                rooms_opened++;
                room = rooms_opened;
            end
            else
                b.full = 1'b1;
        end
        b.index  = idx;
        b.room   = ROOM_W'(room);
        b.in_use = ROOM_W'(rooms_opened);
        return b;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        booking_t want;
        booking_t got;
        if (!rst_n)
        begin
            rooms_opened = 0;
            error_count  = 0;
            booked_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                booked_q.insert(booked_q.size(),
                                assign_room(start_time, end_time, item_index));
            if (out_valid && !out_stall)
            begin
                got = {out_index, room_number, rooms_in_use, overflow};
                if (booked_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result index %0d room %0d in use %0d ovf %0b",
                                 $realtime, got.index, got.room, got.in_use, got.full);
                end
                else
                begin
                    want = booked_q.pop_front();
                    if (got.index != want.index || got.room != want.room ||
                        got.in_use != want.in_use || got.full != want.full)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: expected index %0d room %0d in use %0d ovf %0b, %s",
                                     $realtime, want.index, want.room, want.in_use, want.full,
                                     $sformatf("got %0d %0d %0d %0b", got.index, got.room,
                                               got.in_use, got.full));
                    end
                end
            end
            mismatches  <= error_count;
            outstanding <= booked_q.size();
        end
    end

endmodule

@@ bench/interval_room_allocator_test.sv @@
`timescale 1ns / 1ps

module interval_room_allocator_test;
    import ira_pkg::*;

    // Longest stretch without any handshake before the run is declared hung.
    // The slowest correct item scans every room and may meet random
    // stalls, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    // Quiet time after the last result; covers the worst latency of a full table.
    localparam int SETTLE_CYCLES  = 300;
    localparam int SESSIONS       = 24;
    // Enough zero-start intervals to open every remaining room and then overflow.
    localparam int FILL_ITEMS     = MAX_ROOMS_DEF + 4;

    // Traffic shapes applied to the item and result channels.
    typedef enum int {
        TRAFFIC_OPEN,
        TRAFFIC_SLOW_SOURCE,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_BOTH
    } traffic_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_stall;
    logic [TIME_W-1:0]  start_time = '0;
    logic [TIME_W-1:0]  end_time   = '0;
    logic [INDEX_W-1:0] item_index = '0;
    logic               out_valid;
    logic               out_stall  = 1'b0;
    logic [INDEX_W-1:0] out_index;
    logic [ROOM_W-1:0]  room_number;
    logic [ROOM_W-1:0]  rooms_in_use;
    logic               overflow;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int quiet_cycles = 0;
    int mismatches;
    int outstanding;

    always #1 clk = ~clk;

    interval_room_allocator #(
        .MAX_ROOMS(MAX_ROOMS_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_time  (start_time),
        .end_time    (end_time),
        .item_index  (item_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_index   (out_index),
        .room_number (room_number),
        .rooms_in_use(rooms_in_use),
        .overflow    (overflow)
    );

    // The checker predicts every room decision and compares each result item.
    interval_room_allocator_checker #(
        .MAX_ROOMS(MAX_ROOMS_DEF)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .start_time  (start_time),
        .end_time    (end_time),
        .item_index  (item_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_index   (out_index),
        .room_number (room_number),
        .rooms_in_use(rooms_in_use),
        .overflow    (overflow),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The result side stalls at random, with a probability set by the
    // current traffic shape.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Watchdog: any cycle without a handshake on either channel counts toward
    // the limit; a handshake clears it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            TRAFFIC_OPEN:
            begin
                idle_pct  <= 0;
                stall_pct <= 0;
            end
            TRAFFIC_SLOW_SOURCE:
            begin
                idle_pct  <= 62;
                stall_pct <= 0;
            end
            TRAFFIC_SLOW_SINK:
            begin
                idle_pct  <= 0;
                stall_pct <= 62;
            end
            default:
            begin
                idle_pct  <= 23;
                stall_pct <= 23;
            end
        endcase
    endtask

    // Offers one interval and returns at the edge where it is taken. Valid is
    // left high on return so that a following item goes out back to back; the
    // caller lowers it when the source is to fall silent. The idle decision is
    // made before the item is shown, so valid never follows the stall.
    task automatic offer_booking(input logic [TIME_W-1:0]  s,
                                 input logic [TIME_W-1:0]  e,
                                 input logic [INDEX_W-1:0] idx);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_time <= s;
        end_time   <= e;
        item_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Holds the source back until every predicted result has come out. The
    // first edge lets the checker count the item that was just taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        longint base;
        longint start_at;
        longint end_at;
        longint prev_start;
        longint prev_end;
        int     gap;
        int     span;
        int     count;
        int     sess;
        int     n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run without idling. The first interval meets an empty
        // table and opens room 1.
        set_traffic(TRAFFIC_OPEN);
        offer_booking(32'd0, 32'd0, 16'h0000);
        // A start equal to the earliest end is not free: room 2 opens.
        offer_booking(32'd0, 32'd5, 16'h0001);
        // Start one past the earliest end reuses room 1.
        offer_booking(32'd1, 32'd3, 16'h0002);
        offer_booking(32'd4, 32'd9, 16'h0003);
        offer_booking(32'd6, 32'd9, 16'h0004);
        // Both rooms now end at the same time, so the lower room wins the tie.
        offer_booking(32'd10, 32'd12, 16'h0005);
        offer_booking(32'd10, 32'd10, 16'h0006);
        // An end before the start is stored as given.
        offer_booking(32'd20, 32'd15, 16'h0007);
        // An interval out of order still follows the greedy rule.
        offer_booking(32'd3, 32'd30, 16'h0008);
        // Field extremes and alternating bit patterns.
        offer_booking(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
        offer_booking(32'h8000_0000, 32'hFFFF_FFFF, 16'h8000);
        offer_booking(32'h0000_0001, 32'h7FFF_FFFF, 16'h7FFF);
        offer_booking(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555);
        offer_booking(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        drain_results();

        // Random sessions. Each one is a sorted run of bookings that starts in a
        // higher slice of the time axis, so rooms from earlier sessions become
        // free again and the table keeps being searched and reused. The
        // spacing and length vary per session to change how many rooms overlap.
        // About one item in ten is an arbitrary interval that breaks the order.
        prev_start = 0;
        prev_end   = 0;
        for (sess = 0; sess < SESSIONS; sess++)
        begin
            set_traffic(traffic_t'(sess % 4));
            base = longint'(sess) * 64'h0A00_0000 + longint'($urandom_range(0, 32'h00FF_FFFF));
            case ($urandom_range(0, 3))
                0:       gap = 1;
                1:       gap = 4;
                2:       gap = 64;
                default: gap = 1000;
            endcase
            span     = gap * $urandom_range(1, 12);
            count    = $urandom_range(16, 28);
            start_at = base;
            for (n = 0; n < count; n++)
            begin
                if ($urandom_range(0, 9) == 0)
                    offer_booking($urandom, $urandom, INDEX_W'($urandom));
                else
                begin
                    start_at += $urandom_range(0, gap);
                    end_at    = start_at + $urandom_range(0, span);
                    // Keep equal starts ordered by end.
                    if (start_at == prev_start && end_at < prev_end)
                        end_at = prev_end;
                    offer_booking(TIME_W'(start_at), TIME_W'(end_at), INDEX_W'($urandom));
                    prev_start = start_at;
                    prev_end   = end_at;
                end
            end
            // One mid-run pause until the block has caught up completely.
            if (sess == SESSIONS / 2)
                drain_results();
        end
        drain_results();

        // A start of zero can never follow any stored end, so each of these
        // opens a room until the table is full, and the last few overflow.
        for (n = 0; n < FILL_ITEMS; n++)
        begin
            set_traffic(traffic_t'((n / 65) % 4));
            offer_booking(32'd0, $urandom, INDEX_W'($urandom));
        end

        // With every room taken, a late enough start still reuses a room.
        set_traffic(TRAFFIC_BOTH);
        for (n = 0; n < 6; n++)
            offer_booking(32'hFFFF_FFFF, $urandom, INDEX_W'($urandom));

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ interval_room_allocator.f @@
rtl/core/ira_pkg.sv
rtl/core/ira_ram.sv
rtl/core/ira_ctrl.sv
rtl/core/ira_dp.sv
rtl/core/interval_room_allocator.sv
bench/interval_room_allocator_checker.sv
bench/interval_room_allocator_test.sv
